[rtl/ebm_pkg.sv]
package ebm_pkg;

  localparam logic [31:0] WINDOW_RESET = 32'd96000000;
  localparam logic [31:0] ALL32        = 32'hFFFF_FFFF;
  localparam logic [15:0] SAT16        = 16'hFFFF;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } ebm_op_t;

  // measurement fields of one result, everything but the stored-interval readback
  typedef struct packed {
    logic        done;
    logic        edge_seen;
    logic [31:0] interval;
    logic [31:0] edge_count;
    logic [31:0] shortest_interval;
  } ebm_meas_t;

  function automatic logic [15:0] sat16(input logic [31:0] value);
    logic [15:0] res;
    res = (value > 32'(SAT16)) ? SAT16 : value[15:0];
    return res;
  endfunction

endpackage

[rtl/edge_interval_baud_meter.sv]
// Auto-baud meter: one sample transaction is one clock tick of the measured wire.
// The first sample after reset fixes the reference level and time zero; from then on,
// until window_cycles ticks have gone by, every level change counts an edge, reports
// the ticks since the previous edge and keeps the smallest such interval, which is
// the bit period. The first CAPTURE_DEPTH intervals are kept in an on-chip memory,
// saturated to 16 bits, and a read transaction returns one of them (0 for a slot not
// yet filled). Once the window has run out, done_res is 1 and samples are ignored.
// The block takes one transaction every clock while in_stall is low and returns one
// result per transaction via the middle stage and the output register: the timing
// registers are updated in the cycle of acceptance (one subtract and compare), the
// interval memory is read in that same cycle, its data held beside the middle stage.
// A result that waits at the output does not block the input while the middle
// stage is free. No clearing pass is needed after reset: the edge counter tells
// which slots hold data. window_cycles may be written only while the block is idle.
module edge_interval_baud_meter #(
  parameter int CAPTURE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: window length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic        pin_level,
  input  logic [5:0]  read_index,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic        done_res,
  output logic        edge_seen,
  output logic [31:0] interval,
  output logic [31:0] edge_count,
  output logic [31:0] shortest_interval,
  output logic [15:0] read_data
);

  import ebm_pkg::*;

  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

  logic [31:0]   window_cycles;
  logic          accept;
  ebm_meas_t     meas;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [15:0]   mem_q;

  // middle stage: waits for the memory read data
  logic          s1_valid;
  ebm_meas_t     s1_meas;
  logic          s1_rd_ok;
  logic          s1_move;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_cycles <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_cycles <= cfg_data;
    end
  end

  // handshake: the middle stage empties into the output register when that is free
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  ebm_core #(
    .DEPTH (CAPTURE_DEPTH),
    .AW    (AW)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .opcode        (opcode),
    .pin_level     (pin_level),
    .read_index    (read_index),
    .window_cycles (window_cycles),
    .meas          (meas),
    .rd_ok         (rd_ok),
    .rd_addr       (rd_addr),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  // writes and reads come from different transactions, so a read always
  // sees every earlier write without forwarding
  ebm_store #(
    .DEPTH (CAPTURE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept && rd_ok),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meas  <= meas;
      s1_rd_ok <= rd_ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      done_res          <= s1_meas.done;
      edge_seen         <= s1_meas.edge_seen;
      interval          <= s1_meas.interval;
      edge_count        <= s1_meas.edge_count;
      shortest_interval <= s1_meas.shortest_interval;
      read_data         <= s1_rd_ok ? mem_q : '0;
    end
  end

  // an edge always has a non-zero interval no smaller than the running minimum
  a_edge_interval : assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_seen |->
      interval != '0 && shortest_interval != '0 && shortest_interval <= interval)
    else $error("edge result with inconsistent interval or minimum");

  // stored data can only come back once some edge has been counted
  a_read_after_edge : assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != '0 |-> edge_count != '0 && !edge_seen)
    else $error("read data returned with no edge counted");

  // the input is held off only while both pipeline stages are occupied
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled with a free pipeline stage");

endmodule

[rtl/ebm_store.sv]
module ebm_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/ebm_core.sv]
module ebm_core #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               opcode,
  input  logic               pin_level,
  input  logic [5:0]         read_index,
  input  logic [31:0]        window_cycles,
  output ebm_pkg::ebm_meas_t meas,
  output logic               rd_ok,
  output logic [AW-1:0]      rd_addr,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [15:0]        wr_data
);

  import ebm_pkg::*;

  logic        primed, primed_next;
  logic        previous_level, previous_level_next;
  logic [31:0] elapsed_ticks, elapsed_ticks_next;
  logic [31:0] last_edge_time, last_edge_time_next;
  logic [31:0] smallest_interval, smallest_interval_next;
  logic [31:0] edges_counted, edges_counted_next;
  logic [31:0] iv;
  logic [31:0] idx_ext;
  logic        seen;
  logic        sample;

  assign sample  = (opcode == OP_SAMPLE);
  assign idx_ext = 32'(read_index);
  assign rd_addr = idx_ext[AW-1:0];
  assign rd_ok   = !sample && (idx_ext < edges_counted) && (idx_ext < 32'(DEPTH));
  assign wr_addr = edges_counted[AW-1:0];
  assign wr_data = sat16(iv);

  always_comb begin
    primed_next            = primed;
    previous_level_next    = previous_level;
    elapsed_ticks_next     = elapsed_ticks;
    last_edge_time_next    = last_edge_time;
    smallest_interval_next = smallest_interval;
    edges_counted_next     = edges_counted;
    iv                     = elapsed_ticks - last_edge_time;
    seen                   = 1'b0;
    wr_en                  = 1'b0;
    if (sample && !primed) begin
      // first sample: reference level and time zero
      primed_next         = 1'b1;
      previous_level_next = pin_level;
      last_edge_time_next = '0;
      elapsed_ticks_next  = 32'd1;
    end else if (sample && (elapsed_ticks < window_cycles)) begin
      if (pin_level != previous_level) begin
        seen                = 1'b1;
        last_edge_time_next = elapsed_ticks;
        previous_level_next = pin_level;
        if (iv < smallest_interval) begin
          smallest_interval_next = iv;
        end
        wr_en = accept && (edges_counted < 32'(DEPTH));
        if (edges_counted != ALL32) begin
          edges_counted_next = edges_counted + 32'd1;
        end
      end
      elapsed_ticks_next = elapsed_ticks + 32'd1;
    end
  end

  always_comb begin
    meas.done              = primed_next && (elapsed_ticks_next >= window_cycles);
    meas.edge_seen         = seen;
    meas.interval          = seen ? iv : '0;
    meas.edge_count        = edges_counted_next;
    meas.shortest_interval = (edges_counted_next == '0) ? '0 : smallest_interval_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed            <= 1'b0;
      previous_level    <= 1'b0;
      elapsed_ticks     <= '0;
      last_edge_time    <= '0;
      smallest_interval <= ALL32;
      edges_counted     <= '0;
    end else if (accept) begin
      primed            <= primed_next;
      previous_level    <= previous_level_next;
      elapsed_ticks     <= elapsed_ticks_next;
      last_edge_time    <= last_edge_time_next;
      smallest_interval <= smallest_interval_next;
      edges_counted     <= edges_counted_next;
    end
  end

endmodule
